FILE: hw/rtl/cfr_pkg.sv
// Shared types and constants for the command frame receiver.
// No dependencies; imported by cfr_ctrl and command_frame_receiver.
package cfr_pkg;

  localparam logic [7:0] SyncFirst   = 8'hAA;
  localparam logic [7:0] SyncSecond  = 8'hCC;
  localparam int unsigned PayloadLen = 8;
  localparam int unsigned CountW     = $clog2(PayloadLen);

  typedef enum logic [1:0] {
    PhHunt  = 2'd0,
    PhSync2 = 2'd1,
    PhData  = 2'd2,
    PhCheck = 2'd3
  } phase_e;

  // Control from the frame sequencer to the datapath.
  typedef struct packed {
    logic shift;        // payload byte arriving, advance the cell chain
    logic hit;          // check byte matched, capture the frame
    logic check_phase;  // next byte is the check byte
  } ctrl_t;

endpackage

FILE: hw/rtl/cfr_cell.sv
// One byte cell of the payload chain: loads from its neighbor on shift.
// Depends on nothing; instantiated by command_frame_receiver.
module cfr_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] d_i,
  output logic [7:0] q_o
);

  logic [7:0] data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= d_i;
    end
  end

  assign q_o = data_q;

endmodule

FILE: hw/rtl/cfr_ctrl.sv
// Frame sequencer: sync hunt, payload count and running XOR check.
// Depends on cfr_pkg.
module cfr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    byte_i,
  output cfr_pkg::ctrl_t ctrl_o
);
  import cfr_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        xor_q, xor_d;

  localparam logic [CountW-1:0] LastIdx = CountW'(PayloadLen - 1);

  // next state
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    xor_d   = xor_q;
    if (fire_i) begin
      unique case (phase_q)
        PhHunt: begin
          if (byte_i == SyncFirst) phase_d = PhSync2;
        end
        PhSync2: begin
          if (byte_i == SyncSecond) begin
            xor_d   = SyncFirst ^ SyncSecond;
            count_d = '0;
            phase_d = PhData;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhData: begin
          xor_d   = xor_q ^ byte_i;
          count_d = count_q + 1'b1;
          if (count_q == LastIdx) phase_d = PhCheck;
        end
        PhCheck: begin
          count_d = '0;
          phase_d = PhHunt;
        end
        default: phase_d = PhHunt;
      endcase
    end
  end

  // outputs
  always_comb begin
    ctrl_o             = '0;
    ctrl_o.check_phase = (phase_q == PhCheck);
    unique case (phase_q)
      PhData:  ctrl_o.shift = fire_i;
      PhCheck: ctrl_o.hit   = fire_i && (byte_i == xor_q);
      default: ctrl_o.shift = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      count_q <= '0;
      xor_q   <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      xor_q   <= xor_d;
    end
  end

endmodule

FILE: hw/rtl/command_frame_receiver.sv
// Command frame receiver top level: cell chain, sequencer, result register.
// Depends on cfr_pkg, cfr_cell and cfr_ctrl.
//
// Takes one received byte per cycle. A frame is 0xAA, 0xCC, eight payload
// bytes and a check byte equal to the XOR of all ten preceding bytes; a good
// frame yields one command transaction with the eight payload bytes, a bad one
// is dropped. Payload bytes travel down a chain of eight byte cells, one step
// per payload byte, so after the eighth the first cell holds the accelerator
// byte. The result is registered and appears the cycle after the check byte.
// The input stalls only when a check byte arrives while the previous result
// is still held and not taken in that cycle.
module command_frame_receiver (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        accel_raw_o,
  output logic [7:0]        brake_front_left_o,
  output logic [7:0]        brake_front_right_o,
  output logic [7:0]        brake_rear_left_o,
  output logic [7:0]        brake_rear_right_o,
  output logic signed [7:0] steer_raw_o,
  output logic signed [7:0] gear_select_o,
  output logic [7:0]        clutch_raw_o
);
  import cfr_pkg::*;

  ctrl_t      ctrl;
  logic       fire;
  logic [7:0] chain [PayloadLen+1];
  logic [7:0] res_q [PayloadLen];
  logic       out_valid_q, out_valid_d;

  assign in_ready_o = !(ctrl.check_phase && out_valid_q && !out_ready_i);
  assign fire       = in_valid_i && in_ready_o;

  cfr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (rx_byte_i),
    .ctrl_o (ctrl)
  );

  // new bytes enter at the far end and walk toward cell 0
  assign chain[PayloadLen] = rx_byte_i;

  for (genvar i = 0; i < PayloadLen; i++) begin : g_cell
    cfr_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctrl.shift),
      .d_i     (chain[i+1]),
      .q_o     (chain[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.hit) begin
      for (int k = 0; k < PayloadLen; k++) begin
        res_q[k] <= chain[k];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.hit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign accel_raw_o         = res_q[0];
  assign brake_front_left_o  = res_q[1];
  assign brake_front_right_o = res_q[2];
  assign brake_rear_left_o   = res_q[3];
  assign brake_rear_right_o  = res_q[4];
  assign steer_raw_o         = signed'(res_q[5]);
  assign gear_select_o       = signed'(res_q[6]);
  assign clutch_raw_o        = res_q[7];

  a_hit_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.hit |=> out_valid_o)
    else $error("matched frame did not produce a result");

  a_no_shift_and_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.hit && ctrl.shift))
    else $error("payload shift during check byte");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && ctrl.check_phase))
    else $error("input stalled without a pending result");

  a_result_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.hit |=> (accel_raw_o == $past(chain[0]) && clutch_raw_o == $past(chain[7])))
    else $error("result does not match payload cells");

endmodule
